// ===== rtl/bsc_pkg.sv =====
// bsc_pkg: shared constants, register codes and pipeline payload types
// for the barometric compensation datapath
// no dependencies
package bsc_pkg;

	localparam logic [63:0] TFINE_OFFSET = 64'd128000;
	localparam logic [63:0] PRESS_BASE   = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE  = 64'd3125;
	localparam logic [63:0] TERM_47      = 64'h0000_8000_0000_0000;
	localparam logic [63:0] ROUND_255    = 64'd255;
	localparam logic [31:0] TEMP_ROUND   = 32'd128;
	localparam int unsigned DIV_CELLS    = 64;

	// configuration register index
	typedef enum logic [1:0] {
		REG_TEMP_CAL   = 2'd0,
		REG_PRESS_LOW  = 2'd1,
		REG_PRESS_MID  = 2'd2,
		REG_PRESS_HIGH = 2'd3
	} cfg_reg_e;

	// side data that rides along with the divider
	typedef struct packed {
		logic [31:0] temp;
		logic        neg;
		logic        dz;
	} bsc_side_t;

	// one divider cell payload: partial remainder, dividend/quotient, divisor
	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] num;
		logic [63:0] dvs;
		bsc_side_t   side;
	} bsc_div_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

endpackage

// ===== rtl/bsc_mul64.sv =====
// bsc_mul64: 64x64 multiply modulo 2^64, two pipeline stages
// built from three 32x32 partial products; standalone
module bsc_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [63:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
			lh_s1 <= a[31:0] * b[63:32];
			hl_s1 <= a[63:32] * b[31:0];
			p_s2  <= ll_s1 + {lh_s1 + hl_s1, 32'd0};
		end
	end

	assign p = p_s2;
endmodule

// ===== rtl/bsc_div_cell.sv =====
// bsc_div_cell: one restoring-division step, one quotient bit per cell
// depends on bsc_pkg for the payload type
module bsc_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_up,
	input  bsc_pkg::bsc_div_t up,
	output logic              vld_dn,
	output bsc_pkg::bsc_div_t dn
);
	import bsc_pkg::*;

	logic [64:0] trial;
	logic [64:0] diff;
	logic        ge;
	logic        vld_q;
	bsc_div_t    pay_q;

	always_comb begin
		trial = {up.rem, up.num[63]};
		diff  = trial - {1'b0, up.dvs};
		ge    = trial >= {1'b0, up.dvs};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_up;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q.rem  <= ge ? diff[63:0] : trial[63:0];
			pay_q.num  <= {up.num[62:0], ge};
			pay_q.dvs  <= up.dvs;
			pay_q.side <= up.side;
		end
	end

	assign vld_dn = vld_q;
	assign dn     = pay_q;
endmodule

// ===== rtl/barometric_sensor_compensation_top.sv =====
// barometric_sensor_compensation_top: compensated temperature and pressure
// depends on bsc_pkg, bsc_mul64 and bsc_div_cell
//
// Takes one raw temperature and one raw pressure conversion per transaction
// and returns the temperature in 0.01 degC and the pressure in pascals,
// using the integer compensation polynomials and the twelve calibration
// words in the four configuration registers. The block is one pipeline that
// takes a new transaction every cycle unless sample_stall is raised. It forms
// the temperature and pressure polynomial terms (64-bit products formed from
// 32x32 partial products over two stages), then does sign handling, then a
// row of 64 divider cells that each settle one quotient bit of the 64-bit
// signed division, then final pressure correction and scaling ending in the
// output register.
// When the result register holds a transaction that is stalled, the whole
// pipeline holds and sample_stall is raised. When the pressure divisor is
// zero, pressure_pa is 0 and divisor_zero is set. Configuration writes are
// always ready and should be made only while the pipeline is empty.
module barometric_sensor_compensation_top (
	input  logic        clk,
	input  logic        arst_n,
	// sample channel
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [19:0] temp_raw,
	input  logic [19:0] press_raw,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] temperature_centi,
	output logic [31:0] pressure_pa,
	output logic        divisor_zero,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import bsc_pkg::*;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [47:0] temp_cal_q;
	logic [63:0] pcal_lo_q;
	logic [63:0] pcal_mid_q;
	logic [15:0] pcal_hi_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			pcal_lo_q  <= '0;
			pcal_mid_q <= '0;
			pcal_hi_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_TEMP_CAL:   temp_cal_q <= cfg_data[47:0];
				REG_PRESS_LOW:  pcal_lo_q  <= cfg_data;
				REG_PRESS_MID:  pcal_mid_q <= cfg_data;
				REG_PRESS_HIGH: pcal_hi_q  <= cfg_data[15:0];
			endcase
		end
	end

	// calibration words, sign extended where the polynomial wants it
	logic [15:0] t1;
	logic [31:0] t2_32;
	logic [31:0] t3_32;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

	always_comb begin
		t1    = temp_cal_q[15:0];
		t2_32 = {{16{temp_cal_q[31]}}, temp_cal_q[31:16]};
		t3_32 = {{16{temp_cal_q[47]}}, temp_cal_q[47:32]};
		p1    = {48'd0, pcal_lo_q[15:0]};
		p2    = sx16(pcal_lo_q[31:16]);
		p3    = sx16(pcal_lo_q[47:32]);
		p4    = sx16(pcal_lo_q[63:48]);
		p5    = sx16(pcal_mid_q[15:0]);
		p6    = sx16(pcal_mid_q[31:16]);
		p7    = sx16(pcal_mid_q[47:32]);
		p8    = sx16(pcal_mid_q[63:48]);
		p9    = sx16(pcal_hi_q);
	end

	// ---------------------------------------------------------------
	// flow control: whole pipeline moves unless the result is stalled
	// ---------------------------------------------------------------
	logic pipe_en;
	logic result_vld_s85;

	assign pipe_en      = !(result_vld_s85 && result_stall);
	assign sample_stall = !pipe_en;

	logic [11:0] front_vld_q;   // valid of stages 1..12
	logic        ent_vld_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_vld_q <= '0;
			ent_vld_s13 <= 1'b0;
		end else if (pipe_en) begin
			front_vld_q <= {front_vld_q[10:0], sample_valid};
			ent_vld_s13 <= front_vld_q[11];
		end
	end

	// ---------------------------------------------------------------
	// temperature, 32-bit wrapping (stages 1..4)
	// ---------------------------------------------------------------
	logic [31:0] a0, dt, tb_in, tb_sh;
	logic [31:0] ta_s1, dd_s1;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3;
	logic [31:0] v1_s2, tb_s2;
	logic [31:0] fine_s3;
	logic [31:0] fine5;
	logic [31:0] temp_s4;
	logic [63:0] x1_s4, pn_s4;

	always_comb begin
		a0    = {15'd0, temp_raw[19:3]} - {15'd0, t1, 1'b0};
		dt    = {16'd0, temp_raw[19:4]} - {16'd0, t1};
		tb_in = $signed(dd_s1) >>> 12;
		// arithmetic shift kept apart from the unsigned sum
		tb_sh = $signed(tb_s2) >>> 14;
		fine5 = {fine_s3[29:0], 2'b00} + fine_s3 + TEMP_ROUND;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ta_s1   <= a0 * t2_32;
			dd_s1   <= dt * dt;
			adcp_s1 <= press_raw;
			v1_s2   <= $signed(ta_s1) >>> 11;
			tb_s2   <= tb_in * t3_32;
			adcp_s2 <= adcp_s1;
			fine_s3 <= v1_s2 + tb_sh;
			adcp_s3 <= adcp_s2;
			temp_s4 <= $signed(fine5) >>> 8;
			x1_s4   <= {{32{fine_s3[31]}}, fine_s3} - TFINE_OFFSET;
			pn_s4   <= PRESS_BASE - {44'd0, adcp_s3};
		end
	end

	// ---------------------------------------------------------------
	// pressure divisor and dividend terms (stages 5..12)
	// ---------------------------------------------------------------
	logic [63:0] m1_s6, m2_s6, m3_s6;
	logic [63:0] m4_s8, m5_s8;
	logic [63:0] m6_s12, m7_s12;

	bsc_mul64 u_m1 (.clk(clk), .en(pipe_en), .a(x1_s4), .b(x1_s4), .p(m1_s6));
	bsc_mul64 u_m2 (.clk(clk), .en(pipe_en), .a(x1_s4), .b(p5), .p(m2_s6));
	bsc_mul64 u_m3 (.clk(clk), .en(pipe_en), .a(x1_s4), .b(p2), .p(m3_s6));
	bsc_mul64 u_m4 (.clk(clk), .en(pipe_en), .a(m1_s6), .b(p6), .p(m4_s8));
	bsc_mul64 u_m5 (.clk(clk), .en(pipe_en), .a(m1_s6), .b(p3), .p(m5_s8));

	logic [31:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10;
	logic [31:0] temp_s11, temp_s12;
	logic [63:0] pn_s5, pn_s6, pn_s7, pn_s8, pn_s9;
	logic [63:0] m2_s7, m2_s8, m3_s7, m3_s8;
	logic [63:0] m5_sh;
	logic [63:0] x2_s9, x1b_s9;
	logic [63:0] x1s_s10, nm_s10;

	assign m5_sh = $signed(m5_s8) >>> 8;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			temp_s5  <= temp_s4;
			temp_s6  <= temp_s5;
			temp_s7  <= temp_s6;
			temp_s8  <= temp_s7;
			temp_s9  <= temp_s8;
			temp_s10 <= temp_s9;
			temp_s11 <= temp_s10;
			temp_s12 <= temp_s11;
			pn_s5    <= pn_s4;
			pn_s6    <= pn_s5;
			pn_s7    <= pn_s6;
			pn_s8    <= pn_s7;
			pn_s9    <= pn_s8;
			m2_s7    <= m2_s6;
			m2_s8    <= m2_s7;
			m3_s7    <= m3_s6;
			m3_s8    <= m3_s7;
			x2_s9    <= m4_s8 + (m2_s8 << 17) + (p4 << 35);
			x1b_s9   <= m5_sh + (m3_s8 << 12);
			x1s_s10  <= TERM_47 + x1b_s9;
			nm_s10   <= (pn_s9 << 31) - x2_s9;
		end
	end

	bsc_mul64 u_m6 (.clk(clk), .en(pipe_en), .a(x1s_s10), .b(p1), .p(m6_s12));
	bsc_mul64 u_m7 (.clk(clk), .en(pipe_en), .a(nm_s10), .b(PRESS_SCALE), .p(m7_s12));

	// ---------------------------------------------------------------
	// stage 13: magnitudes and signs for the divider row
	// ---------------------------------------------------------------
	logic [63:0] x1f;
	bsc_div_t    ent_s13;

	assign x1f = $signed(m6_s12) >>> 33;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ent_s13.rem       <= '0;
			ent_s13.num       <= m7_s12[63] ? (64'd0 - m7_s12) : m7_s12;
			ent_s13.dvs       <= x1f[63] ? (64'd0 - x1f) : x1f;
			ent_s13.side.temp <= temp_s12;
			ent_s13.side.neg  <= m7_s12[63] ^ x1f[63];
			ent_s13.side.dz   <= (x1f == 64'd0);
		end
	end

	// ---------------------------------------------------------------
	// divider row: one quotient bit per cell, stages 14..77
	// ---------------------------------------------------------------
	bsc_div_t div_link [DIV_CELLS+1];
	logic     div_vld  [DIV_CELLS+1];

	assign div_link[0] = ent_s13;
	assign div_vld[0]  = ent_vld_s13;

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
		bsc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (pipe_en),
			.vld_up (div_vld[i]),
			.up     (div_link[i]),
			.vld_dn (div_vld[i+1]),
			.dn     (div_link[i+1])
		);
	end

	// ---------------------------------------------------------------
	// final pressure correction (stages 78..85)
	// ---------------------------------------------------------------
	logic [6:0] back_vld_q;     // valid of stages 78..84

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_vld_q     <= '0;
			result_vld_s85 <= 1'b0;
		end else if (pipe_en) begin
			back_vld_q     <= {back_vld_q[5:0], div_vld[DIV_CELLS]};
			result_vld_s85 <= back_vld_q[6];
		end
	end

	logic [63:0] q_mag;
	logic [63:0] p_s78, p_s79, p_s80, p_s81, p_s82;
	logic [63:0] h_s78, h_s80;
	logic [63:0] y1a_s80, y2a_s80, y2a_s81, y2a_s82, y1b_s82;
	logic [63:0] y1_sh, y2_sh, sum_sh;
	logic [63:0] sum_s83, pp_s84, rnd;
	bsc_side_t   side_s78, side_s79, side_s80, side_s81, side_s82;
	bsc_side_t   side_s83, side_s84;
	logic [31:0] temp_s85, press_s85;
	logic        dz_s85;

	assign q_mag  = div_link[DIV_CELLS].num;
	assign h_s78  = $signed(p_s78) >>> 13;
	assign h_s80  = $signed(p_s80) >>> 13;
	assign y1_sh  = $signed(y1b_s82) >>> 25;
	assign y2_sh  = $signed(y2a_s82) >>> 19;
	assign sum_sh = $signed(sum_s83) >>> 8;
	// division by 256 truncating toward zero
	assign rnd    = pp_s84 + (pp_s84[63] ? ROUND_255 : 64'd0);

	bsc_mul64 u_m8  (.clk(clk), .en(pipe_en), .a(p9), .b(h_s78), .p(y1a_s80));
	bsc_mul64 u_m9  (.clk(clk), .en(pipe_en), .a(p8), .b(p_s78), .p(y2a_s80));
	bsc_mul64 u_m10 (.clk(clk), .en(pipe_en), .a(y1a_s80), .b(h_s80), .p(y1b_s82));

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			p_s78    <= div_link[DIV_CELLS].side.neg ? (64'd0 - q_mag) : q_mag;
			side_s78 <= div_link[DIV_CELLS].side;
			p_s79    <= p_s78;
			p_s80    <= p_s79;
			p_s81    <= p_s80;
			p_s82    <= p_s81;
			side_s79 <= side_s78;
			side_s80 <= side_s79;
			side_s81 <= side_s80;
			side_s82 <= side_s81;
			y2a_s81  <= y2a_s80;
			y2a_s82  <= y2a_s81;
			sum_s83  <= p_s82 + y1_sh + y2_sh;
			side_s83 <= side_s82;
			pp_s84   <= sum_sh + (p7 << 4);
			side_s84 <= side_s83;
			temp_s85 <= side_s84.temp;
			dz_s85   <= side_s84.dz;
			press_s85 <= side_s84.dz ? 32'd0 : rnd[39:8];
		end
	end

	assign result_valid      = result_vld_s85;
	assign temperature_centi = temp_s85;
	assign pressure_pa       = press_s85;
	assign divisor_zero      = dz_s85;

`ifndef SYNTHESIS
	// a zero divisor always yields a zero pressure
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && divisor_zero |-> pressure_pa == 32'd0)
		else $error("divisor_zero with nonzero pressure");

	// the divider row leaves a remainder below a nonzero divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld[DIV_CELLS] && (div_link[DIV_CELLS].dvs != 64'd0)
		|-> div_link[DIV_CELLS].rem < div_link[DIV_CELLS].dvs)
		else $error("divider remainder not below divisor");

	// a held pipeline keeps its occupancy
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(front_vld_q) && $stable(back_vld_q))
		else $error("pipeline moved while held");
`endif
endmodule

// ===== bench/barometric_sensor_compensation_top_tb.sv =====
// barometric_sensor_compensation_top_tb: self-checking bench for the compensation pipeline
// depends on bsc_pkg and barometric_sensor_compensation_top
// predicts each result from the calibration registers and checks it field by field
`timescale 1ns / 1ps

module barometric_sensor_compensation_top_tb;
	import bsc_pkg::*;

	localparam int PIPE_LATENCY = 85;
	localparam longint CYCLE_LIMIT = 1_500_000;

	typedef struct packed {
		logic [31:0] temperature;
		logic [31:0] pressure;
		logic        dz;
	} comp_result_t;

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_stall;
	logic [19:0] temp_raw;
	logic [19:0] press_raw;
	logic        result_valid;
	logic        result_stall;
	logic [31:0] temperature_centi;
	logic [31:0] pressure_pa;
	logic        divisor_zero;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	// calibration shadow copies
	logic [47:0] cal_temp;
	logic [63:0] cal_plow;
	logic [63:0] cal_pmid;
	logic [15:0] cal_phigh;

	comp_result_t expected_results[$];
	int     error_count;
	int     checked_count;
	int     zero_div_count;
	longint cycle_count;
	// stall pattern mode for the result side
	int     stall_mode;

	barometric_sensor_compensation_top u_top (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.temp_raw(temp_raw), .press_raw(press_raw),
		.result_valid(result_valid), .result_stall(result_stall),
		.temperature_centi(temperature_centi), .pressure_pa(pressure_pa),
		.divisor_zero(divisor_zero),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle counter guards against a hung pipeline
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	// signed division truncating toward zero, most negative / -1 wraps
	function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ma, mb, q;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		q = ma / mb;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	// compensation polynomials on the current calibration words
	function automatic comp_result_t compensate(input logic [19:0] adc_t,
			input logic [19:0] adc_p);
		logic signed [31:0] t1, t2, t3, tv1, tv2, dt, fine;
		logic signed [63:0] x1, x2, p, h, y1, y2;
		logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, fine64;
		comp_result_t r;
		t1 = {16'd0, cal_temp[15:0]};
		t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
		t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
		tv1 = $signed((({12'd0, adc_t} >> 3) - (t1 << 1)) * t2) >>> 11;
		dt = ({12'd0, adc_t} >> 4) - t1;
		tv2 = (((dt * dt) >>> 12) * t3) >>> 14;
		fine = tv1 + tv2;
		r.temperature = (fine * 5 + 128) >>> 8;
		p1 = {48'd0, cal_plow[15:0]};
		p2 = {{48{cal_plow[31]}}, cal_plow[31:16]};
		p3 = {{48{cal_plow[47]}}, cal_plow[47:32]};
		p4 = {{48{cal_plow[63]}}, cal_plow[63:48]};
		p5 = {{48{cal_pmid[15]}}, cal_pmid[15:0]};
		p6 = {{48{cal_pmid[31]}}, cal_pmid[31:16]};
		p7 = {{48{cal_pmid[47]}}, cal_pmid[47:32]};
		p8 = {{48{cal_pmid[63]}}, cal_pmid[63:48]};
		p9 = {{48{cal_phigh[15]}}, cal_phigh};
		fine64 = {{32{fine[31]}}, fine};
		x1 = fine64 - 64'sd128000;
		x2 = x1 * x1 * p6;
		x2 = x2 + ((x1 * p5) << 17);
		x2 = x2 + (p4 << 35);
		x1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) << 12);
		x1 = (((64'sd1 << 47) + x1) * p1) >>> 33;
		r.pressure = '0;
		r.dz = 1'b0;
		if (x1 == 0) begin
			r.dz = 1'b1;
		end else begin
			p = 64'sd1048576 - {44'd0, adc_p};
			p = div_trunc(((p << 31) - x2) * 64'sd3125, x1);
			h = p >>> 13;
			y1 = (p9 * h * h) >>> 25;
			y2 = (p8 * p) >>> 19;
			p = ((p + y1 + y2) >>> 8) + (p7 << 4);
			p = div_trunc(p, 64'd256);
			r.pressure = p[31:0];
		end
		return r;
	endfunction

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		comp_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result temp=%0d press=%0d", $time,
					$signed(temperature_centi), pressure_pa);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				checked_count++;
				if (divisor_zero) zero_div_count++;
				if (temperature_centi !== want.temperature) begin
					$display("%0t: temperature_centi expected %0d actual %0d", $time,
						$signed(want.temperature), $signed(temperature_centi));
					error_count++;
				end
				if (pressure_pa !== want.pressure) begin
					$display("%0t: pressure_pa expected %0d actual %0d", $time,
						want.pressure, pressure_pa);
					error_count++;
				end
				if (divisor_zero !== want.dz) begin
					$display("%0t: divisor_zero expected %0b actual %0b", $time,
						want.dz, divisor_zero);
					error_count++;
				end
			end
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 1) == 0);
			default: result_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	task automatic write_reg(input cfg_reg_e idx, input logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TEMP_CAL:   cal_temp  = value[47:0];
			REG_PRESS_LOW:  cal_plow  = value;
			REG_PRESS_MID:  cal_pmid  = value;
			REG_PRESS_HIGH: cal_phigh = value[15:0];
		endcase
	endtask

	task automatic load_calibration(input logic [47:0] tc, input logic [63:0] pl,
			input logic [63:0] pm, input logic [15:0] ph);
		write_reg(REG_TEMP_CAL, {16'd0, tc});
		write_reg(REG_PRESS_LOW, pl);
		write_reg(REG_PRESS_MID, pm);
		write_reg(REG_PRESS_HIGH, {48'd0, ph});
	endtask

	// send one sample; valid stays high into the next send when no gap follows,
	// otherwise valid is dropped after the sample is taken
	task automatic send_sample(input logic [19:0] t, input logic [19:0] p, input bit hold);
		sample_valid <= 1'b1;
		temp_raw  <= t;
		press_raw <= p;
		do @(posedge clk); while (sample_stall);
		expected_results.push_back(compensate(t, p));
		if (!hold) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// wait until the pipeline has drained, then let it settle
	task automatic drain;
		while (expected_results.size() != 0) @(posedge clk);
		sample_valid <= 1'b0;
		repeat (PIPE_LATENCY + 10) @(posedge clk);
	endtask

	// random sample stream in bursts with random gaps
	task automatic random_burst_stream(input int count);
		int left, burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left) burst = left;
			for (int k = 0; k < burst; k++)
				send_sample(20'($urandom), 20'($urandom), k != burst - 1);
			left -= burst;
			if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// typical datasheet-like calibration, raw values around real readings
	task automatic test_typical;
		load_calibration({16'hFC18, 16'h6821, 16'd27504},
			{16'hFFF9, 16'h0BD0, 16'hD60B, 16'd36477},
			{16'h3C5A, 16'hF7F0, 16'h008C, 16'hFFF9}, 16'd6000);
		stall_mode = 0;
		send_sample(20'd519888, 20'd415148, 1);
		send_sample(20'd0, 20'd0, 1);
		send_sample(20'hFFFFF, 20'hFFFFF, 1);
		send_sample(20'd0, 20'hFFFFF, 0);
		send_sample(20'hFFFFF, 20'd0, 0);
		drain();
	endtask

	// zero calibration: divisor is zero, pressure forced to 0
	task automatic test_zero_divisor;
		load_calibration('0, '0, '0, '0);
		send_sample(20'd0, 20'd0, 0);
		send_sample(20'hFFFFF, 20'hFFFFF, 0);
		send_sample(20'h55555, 20'hAAAAA, 0);
		drain();
	endtask

	// all-ones and extreme words exercise wrap in every term
	task automatic test_extremes;
		load_calibration({48{1'b1}}, {64{1'b1}}, {64{1'b1}}, 16'hFFFF);
		send_sample(20'hFFFFF, 20'd0, 1);
		send_sample(20'd0, 20'hFFFFF, 0);
		drain();
		load_calibration({16'h8000, 16'h7FFF, 16'hFFFF},
			{16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
			{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
		send_sample(20'hFFFFF, 20'hFFFFF, 1);
		send_sample(20'h80000, 20'h7FFFF, 1);
		send_sample(20'd1, 20'd1, 0);
		drain();
		// only T1 and P1 set: small divisor, large quotients
		load_calibration({16'd0, 16'd0, 16'd1}, {48'd0, 16'd1}, '0, '0);
		send_sample(20'd0, 20'd0, 0);
		send_sample(20'hFFFFF, 20'hFFFFF, 0);
		drain();
	endtask

	// realistic calibration jitter with random readings, varied pressure
	task automatic test_random_realistic(input int count);
		load_calibration({16'($urandom_range(0, 1000)) - 16'd500,
			16'd26000 + 16'($urandom_range(0, 2000)), 16'd27000 + 16'($urandom_range(0, 2000))},
			{16'hFFF9, 16'd3000 + 16'($urandom_range(0, 200)), 16'hD600, 16'd36000},
			{16'h3C00, 16'hF7F0, 16'h0080, 16'hFFF9}, 16'd6000);
		random_burst_stream(count);
		drain();
	endtask

	// fully random calibration words, any raw values
	task automatic test_random_calibration(input int phases, input int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			stall_mode = ph % 4;
			load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
				{$urandom, $urandom}, 16'($urandom));
			random_burst_stream(per_phase);
			if (ph % 3 == 0) drain();
			else begin
				while (expected_results.size() != 0) @(posedge clk);
				repeat (PIPE_LATENCY + 10) @(posedge clk);
			end
		end
	endtask

	initial begin
		error_count = 0;
		checked_count = 0;
		zero_div_count = 0;
		cycle_count = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		temp_raw = '0;
		press_raw = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TEMP_CAL;
		cfg_data = '0;
		cal_temp = '0;
		cal_plow = '0;
		cal_pmid = '0;
		cal_phigh = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_typical();
		test_zero_divisor();
		test_extremes();
		stall_mode = 1;
		test_random_realistic(400);
		stall_mode = 3;
		test_random_realistic(200);
		test_random_calibration(16, 70);

		$display("checked %0d results over typical, zero-divisor, extreme and random calibrations",
			checked_count);
		$display("%0d results had a zero pressure divisor", zero_div_count);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
